### sv/quoted_word_tokenizer_top_defines.svh
// ----------------------------------------------------------------------------
// quoted word tokenizer assertion macros
// shorthand for clocked checks, held off during reset
// ----------------------------------------------------------------------------
`ifndef QUOTED_WORD_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_TOP_DEFINES_SVH

// condition that must hold at every edge
`define QWT_CHECK(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define QWT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

### sv/qwt_pkg.sv
// ----------------------------------------------------------------------------
// qwt_pkg
// types and constants shared by the quoted word tokenizer
// ----------------------------------------------------------------------------
package qwt_pkg;

    localparam int LINE_LENGTH = 4096;
    localparam int IDX_W       = 12;
    localparam int END_W       = 13;
    localparam int IDX_LIMIT   = (LINE_LENGTH - 1 > 4095) ? 4095 : LINE_LENGTH - 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IDX_LIMIT);

    localparam logic [2:0] MODE_EOL    = 3'd0;
    localparam logic [2:0] MODE_SPACE  = 3'd1;
    localparam logic [2:0] MODE_SQUOTE = 3'd2;
    localparam logic [2:0] MODE_DQUOTE = 3'd3;
    localparam logic [2:0] MODE_CHAR   = 3'd4;
    localparam logic [2:0] MODE_INIT   = 3'd5;

    localparam logic [1:0] STAT_RUN     = 2'd0;
    localparam logic [1:0] STAT_OK      = 2'd1;
    localparam logic [1:0] STAT_PARTIAL = 2'd2;
    localparam logic [1:0] STAT_DONE    = 2'd3;

    typedef enum logic [2:0] {
        ST_WAIT_INIT = 3'd0,
        ST_IDLE      = 3'd1,
        ST_DONE      = 3'd2,
        ST_WORD      = 3'd3,
        ST_SQ        = 3'd4,
        ST_DQ        = 3'd5,
        ST_WORD_SQ   = 3'd6,
        ST_WORD_DQ   = 3'd7
    } t_state;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       closing_quote;
        logic [END_W-1:0] word_end;
        logic [IDX_W-1:0] word_start;
        logic             word_done;
        logic [7:0]       char_out;
        logic             char_valid;
    } t_result;

    localparam int RES_W  = $bits(t_result);
    localparam int DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

### sv/qwt_fsm.sv
// ----------------------------------------------------------------------------
// qwt_fsm
// parse state, quote and word start registers with the per-character logic
// ----------------------------------------------------------------------------
module qwt_fsm
    import qwt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_char,
    input  logic [IDX_W-1:0] i_index,
    output t_result          o_res
);

    t_state           r_state, n_state;
    logic [7:0]       r_quote, n_quote;
    logic [IDX_W-1:0] r_start, n_start;
    logic [IDX_W-1:0] idx;
    logic [2:0]       closer;
    logic             fully;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT_INIT;
            r_quote <= '0;
            r_start <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_quote <= n_quote;
            r_start <= n_start;
        end
    end

    always_comb begin
        idx     = (i_index > IDX_MAX) ? IDX_MAX : i_index;
        n_state = r_state;
        n_quote = r_quote;
        n_start = r_start;
        o_res   = '0;
        fully   = (r_state == ST_SQ) || (r_state == ST_DQ);
        closer  = ((r_state == ST_SQ) || (r_state == ST_WORD_SQ)) ? MODE_SQUOTE : MODE_DQUOTE;
        case (r_state)
            ST_WAIT_INIT: begin
                if (i_mode == MODE_INIT) n_state = ST_IDLE;
            end
            ST_DONE: begin
                o_res.status = STAT_DONE;
            end
            ST_IDLE: begin
                if (i_mode == MODE_EOL) begin
                    o_res.status = STAT_OK;
                    n_state      = ST_DONE;
                end else if (i_mode == MODE_SQUOTE || i_mode == MODE_DQUOTE) begin
                    n_quote = i_char;
                    n_start = idx;
                    n_state = (i_mode == MODE_SQUOTE) ? ST_SQ : ST_DQ;
                end else if (i_mode == MODE_CHAR) begin
                    n_start          = idx;
                    o_res.char_valid = 1'b1;
                    o_res.char_out   = i_char;
                    n_state          = ST_WORD;
                end
            end
            ST_WORD: begin
                if (i_mode == MODE_EOL || i_mode == MODE_SPACE) begin
                    o_res.word_done  = 1'b1;
                    o_res.word_start = r_start;
                    o_res.word_end   = END_W'(idx);
                    if (i_mode == MODE_EOL) begin
                        o_res.status = STAT_OK;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_mode == MODE_SQUOTE || i_mode == MODE_DQUOTE) begin
                    n_quote = i_char;
                    n_state = (i_mode == MODE_SQUOTE) ? ST_WORD_SQ : ST_WORD_DQ;
                end else if (i_mode == MODE_CHAR) begin
                    o_res.char_valid = 1'b1;
                    o_res.char_out   = i_char;
                end
            end
            ST_SQ, ST_DQ, ST_WORD_SQ, ST_WORD_DQ: begin
                if (i_mode == MODE_EOL) begin
                    o_res.word_done  = 1'b1;
                    o_res.word_start = r_start;
                    o_res.word_end   = END_W'(idx);
                    o_res.status     = STAT_PARTIAL;
                    n_state          = ST_DONE;
                end else if (i_mode == closer) begin
                    if (fully) begin
                        o_res.word_done     = 1'b1;
                        o_res.word_start    = r_start;
                        o_res.word_end      = END_W'(idx) + END_W'(1);
                        o_res.closing_quote = r_quote;
                        n_state             = ST_IDLE;
                    end else begin
                        n_state = ST_WORD;
                    end
                end else if (i_mode == MODE_SPACE || i_mode == MODE_SQUOTE ||
                             i_mode == MODE_DQUOTE || i_mode == MODE_CHAR) begin
                    o_res.char_valid = 1'b1;
                    o_res.char_out   = i_char;
                end
            end
            default: begin
                n_state = ST_WAIT_INIT;
            end
        endcase
    end

endmodule

### sv/quoted_word_tokenizer_top.sv
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_top
// path: input stage registers each transfer, parse logic fills result stage
// throughput: one character per cycle unless i_m_tready stalls the output
// reset: synchronous active-low i_rst_n empties both stages and returns the
// parser to awaiting init with quote and word start cleared
// ----------------------------------------------------------------------------
`include "quoted_word_tokenizer_top_defines.svh"

module quoted_word_tokenizer_top
    import qwt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,  // char_in, char_index, zero pad
    input  logic [2:0]        i_s_tuser,  // mode
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata   // char_valid, char_out, word_done,
                                          // word_start, word_end,
                                          // closing_quote, status, zero pad
);

    logic             r_in_valid;
    logic [2:0]       r_in_mode;
    logic [7:0]       r_in_char;
    logic [IDX_W-1:0] r_in_index;
    logic             r_out_valid;
    t_result          r_out_res;
    t_result          res;
    logic             step;

    // item moves from input stage to result stage
    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode  <= i_s_tuser;
            r_in_char  <= i_s_tdata[7:0];
            r_in_index <= i_s_tdata[19:8];
        end
    end

    qwt_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_mode  (r_in_mode),
        .i_char  (r_in_char),
        .i_index (r_in_index),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_W'(r_out_res);

    `QWT_IMPLY(a_char_xor_word, r_out_valid,
        !(r_out_res.char_valid && r_out_res.word_done),
        "char and word end in one transfer")
    `QWT_IMPLY(a_idle_word_zero, r_out_valid && !r_out_res.word_done,
        r_out_res.word_start == '0 && r_out_res.word_end == '0 &&
        r_out_res.closing_quote == '0,
        "word fields set without a finished word")
    `QWT_IMPLY(a_partial_has_word, r_out_valid && r_out_res.status == STAT_PARTIAL,
        r_out_res.word_done && r_out_res.closing_quote == '0,
        "incomplete status without partial word")
    `QWT_IMPLY(a_done_quiet, r_out_valid && r_out_res.status == STAT_DONE,
        !r_out_res.word_done && !r_out_res.char_valid,
        "already done result carries data")
    `QWT_CHECK(a_step_needs_item, !step || r_in_valid, "parser stepped without an item")

endmodule

### dv/quoted_word_tokenizer_top_tb.sv
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_top_tb
// streams one tokenised line of character events through the block and
// compares every result transfer against a cycle-free model of the word
// splitter; the line runs long, so the end-of-line context is picked at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_word_tokenizer_top_tb;
    import qwt_pkg::*;

    localparam int BODY_EVENTS = 1700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [2:0]       mode;
        logic [IDX_W-1:0] idx;
        logic [7:0]       ch;
    } t_tok_event;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              o_s_tready;
    logic [23:0]       s_tdata;
    logic [2:0]        s_tuser;
    logic              o_m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] o_m_tdata;

    t_tok_event  event_q[$];
    t_result     result_q[$];
    t_tok_event  nxt_ev;
    t_tok_event  acc_ev;
    t_result     got;
    t_result     want;
    int          n_events;
    int          acc_cnt;
    int          fail_cnt;
    int          cycle_cnt;

    t_state           tok_state;
    logic [7:0]       tok_quote;
    logic [IDX_W-1:0] tok_start;

    quoted_word_tokenizer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int phase_of(int n);
        if (n < n_events / 3) begin
            return 0;
        end
        if (n < (2 * n_events) / 3) begin
            return 1;
        end
        return 2;
    endfunction

    function automatic t_result tokenize_event(t_tok_event ev);
        t_result          r;
        logic [IDX_W-1:0] idx;
        logic [2:0]       closer;
        logic             fully;
        r = '0;
        idx = (ev.idx > IDX_MAX) ? IDX_MAX : ev.idx;
        case (tok_state)
            ST_WAIT_INIT: begin
                if (ev.mode == MODE_INIT) begin
                    tok_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                r.status = STAT_DONE;
            end
            ST_IDLE: begin
                if (ev.mode == MODE_EOL) begin
                    r.status = STAT_OK;
                    tok_state = ST_DONE;
                end else if (ev.mode == MODE_SQUOTE || ev.mode == MODE_DQUOTE) begin
                    tok_quote = ev.ch;
                    tok_start = idx;
                    tok_state = (ev.mode == MODE_SQUOTE) ? ST_SQ : ST_DQ;
                end else if (ev.mode == MODE_CHAR) begin
                    tok_start = idx;
                    r.char_valid = 1'b1;
                    r.char_out = ev.ch;
                    tok_state = ST_WORD;
                end
            end
            ST_WORD: begin
                if (ev.mode == MODE_EOL || ev.mode == MODE_SPACE) begin
                    r.word_done = 1'b1;
                    r.word_start = tok_start;
                    r.word_end = {1'b0, idx};
                    if (ev.mode == MODE_EOL) begin
                        r.status = STAT_OK;
                        tok_state = ST_DONE;
                    end else begin
                        tok_state = ST_IDLE;
                    end
                end else if (ev.mode == MODE_SQUOTE || ev.mode == MODE_DQUOTE) begin
                    tok_quote = ev.ch;
                    tok_state = (ev.mode == MODE_SQUOTE) ? ST_WORD_SQ : ST_WORD_DQ;
                end else if (ev.mode == MODE_CHAR) begin
                    r.char_valid = 1'b1;
                    r.char_out = ev.ch;
                end
            end
            default: begin
                fully = (tok_state == ST_SQ || tok_state == ST_DQ);
                closer = (tok_state == ST_SQ || tok_state == ST_WORD_SQ) ?
                         MODE_SQUOTE : MODE_DQUOTE;
                if (ev.mode == MODE_EOL) begin
                    r.word_done = 1'b1;
                    r.word_start = tok_start;
                    r.word_end = {1'b0, idx};
                    r.status = STAT_PARTIAL;
                    tok_state = ST_DONE;
                end else if (ev.mode == closer) begin
                    if (fully) begin
                        r.word_done = 1'b1;
                        r.word_start = tok_start;
                        r.word_end = {1'b0, idx} + 1'b1;
                        r.closing_quote = tok_quote;
                        tok_state = ST_IDLE;
                    end else begin
                        tok_state = ST_WORD;
                    end
                end else if (ev.mode == MODE_SPACE || ev.mode == MODE_SQUOTE ||
                             ev.mode == MODE_DQUOTE || ev.mode == MODE_CHAR) begin
                    r.char_valid = 1'b1;
                    r.char_out = ev.ch;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_fld(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    // stimulus builders
    task automatic push_ev(input logic [2:0] m, input logic [7:0] c,
                           input logic [IDX_W-1:0] i);
        t_tok_event ev;
        ev.mode = m;
        ev.ch = c;
        ev.idx = i;
        event_q.push_back(ev);
    endtask

    function automatic logic [IDX_W-1:0] rnd_idx();
        return IDX_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [7:0] quote_byte(logic [2:0] m);
        if ($urandom_range(1) == 0) begin
            return (m == MODE_SQUOTE) ? 8'h27 : 8'h22;
        end
        return 8'($urandom);
    endfunction

    task automatic add_quoted_body(input logic [2:0] closer);
        logic [2:0] other;
        int         n;
        int         k;
        other = (closer == MODE_SQUOTE) ? MODE_DQUOTE : MODE_SQUOTE;
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(5))
                0:       push_ev(MODE_SPACE, 8'h20, rnd_idx());
                1:       push_ev(other, quote_byte(other), rnd_idx());
                default: push_ev(MODE_CHAR, 8'($urandom), rnd_idx());
            endcase
        end
    endtask

    initial begin
        logic [2:0] qm;
        int         k;
        int         n;
        i_rst_n = 1'b0;
        fail_cnt = 0;

        // ignored before init
        push_ev(MODE_EOL, 8'h00, 12'd0);
        push_ev(MODE_CHAR, 8'hff, 12'hfff);
        push_ev(3'd6, 8'h41, 12'd5);
        push_ev(3'd7, 8'h42, 12'd6);
        push_ev(MODE_SPACE, 8'h20, 12'd7);
        push_ev(MODE_SQUOTE, 8'h27, 12'd8);
        push_ev(MODE_INIT, 8'h00, 12'd0);
        // init and undefined modes while running
        push_ev(MODE_INIT, 8'h55, 12'd1);
        push_ev(3'd6, 8'haa, 12'd2);
        push_ev(3'd7, 8'h5a, 12'd3);
        // regular word with an embedded quoted section
        push_ev(MODE_CHAR, 8'h00, 12'd0);
        push_ev(MODE_CHAR, 8'hff, 12'hfff);
        push_ev(MODE_SQUOTE, 8'h27, 12'd20);
        push_ev(MODE_SPACE, 8'h20, 12'd21);
        push_ev(MODE_DQUOTE, 8'h22, 12'd22);
        push_ev(MODE_SQUOTE, 8'h27, 12'd23);
        push_ev(MODE_CHAR, 8'h61, 12'd24);
        push_ev(MODE_SPACE, 8'h20, 12'hfff);
        // fully quoted word closing at the top index
        push_ev(MODE_SQUOTE, 8'h27, 12'hfff);
        push_ev(MODE_CHAR, 8'h62, 12'd30);
        push_ev(MODE_SQUOTE, 8'h27, 12'hfff);
        push_ev(MODE_SPACE, 8'h20, 12'd40);
        push_ev(MODE_DQUOTE, 8'h22, 12'd41);
        push_ev(MODE_SQUOTE, 8'h27, 12'd42);
        push_ev(MODE_DQUOTE, 8'h22, 12'd43);

        // random body of the line, never an end of line
        n = event_q.size() + BODY_EVENTS;
        while (event_q.size() < n) begin
            if ($urandom_range(99) < 8) begin
                push_ev(3'($urandom_range(5, 7)), 8'($urandom), rnd_idx());
            end
            case ($urandom_range(3))
                0, 1: begin
                    for (k = $urandom_range(1, 8); k > 0; k--) begin
                        push_ev(MODE_CHAR, 8'($urandom), rnd_idx());
                        if ($urandom_range(99) < 15) begin
                            qm = ($urandom_range(1) == 0) ? MODE_SQUOTE : MODE_DQUOTE;
                            push_ev(qm, quote_byte(qm), rnd_idx());
                            add_quoted_body(qm);
                            push_ev(qm, quote_byte(qm), rnd_idx());
                        end
                        if ($urandom_range(99) < 4) begin
                            push_ev(3'($urandom_range(5, 7)), 8'($urandom), rnd_idx());
                        end
                    end
                end
                default: begin
                    qm = ($urandom_range(1) == 0) ? MODE_SQUOTE : MODE_DQUOTE;
                    push_ev(qm, quote_byte(qm), rnd_idx());
                    add_quoted_body(qm);
                    if ($urandom_range(99) < 4) begin
                        push_ev(3'($urandom_range(5, 7)), 8'($urandom), rnd_idx());
                    end
                    push_ev(qm, quote_byte(qm), rnd_idx());
                end
            endcase
            for (k = $urandom_range(1, 3); k > 0; k--) begin
                push_ev(MODE_SPACE, 8'h20, rnd_idx());
            end
        end

        // end of line from a random context
        case ($urandom_range(2))
            0: begin
                push_ev(MODE_EOL, 8'($urandom), rnd_idx());
            end
            1: begin
                push_ev(MODE_CHAR, 8'($urandom), rnd_idx());
                push_ev(MODE_CHAR, 8'($urandom), rnd_idx());
                push_ev(MODE_EOL, 8'($urandom), rnd_idx());
            end
            default: begin
                if ($urandom_range(1) == 0) begin
                    push_ev(MODE_CHAR, 8'($urandom), rnd_idx());
                end
                qm = ($urandom_range(1) == 0) ? MODE_SQUOTE : MODE_DQUOTE;
                push_ev(qm, quote_byte(qm), rnd_idx());
                push_ev(MODE_CHAR, 8'($urandom), rnd_idx());
                push_ev(MODE_EOL, 8'($urandom), rnd_idx());
            end
        endcase
        // after the line is done, init included
        push_ev(MODE_INIT, 8'($urandom), rnd_idx());
        for (k = 0; k < 8; k++) begin
            push_ev(3'($urandom_range(7)), 8'($urandom), rnd_idx());
        end
        n_events = event_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (event_q.size() != 0 || s_tvalid) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            acc_cnt  <= 0;
            tok_state = ST_WAIT_INIT;
            tok_quote = '0;
            tok_start = '0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                acc_ev.mode = s_tuser;
                acc_ev.idx  = s_tdata[19:8];
                acc_ev.ch   = s_tdata[7:0];
                result_q.push_back(tokenize_event(acc_ev));
                acc_cnt <= acc_cnt + 1;
            end
            if (!s_tvalid || o_s_tready) begin
                if (event_q.size() != 0 && $urandom_range(99) >=
                    (phase_of(acc_cnt) == 0 ? 24 : (phase_of(acc_cnt) == 1 ? 66 : 0))) begin
                    nxt_ev = event_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nxt_ev.idx, nxt_ev.ch};
                    s_tuser  <= nxt_ev.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >=
                (phase_of(acc_cnt) == 0 ? 66 : (phase_of(acc_cnt) == 1 ? 24 : 0));
            if (o_m_tvalid && m_tready) begin
                got = t_result'(o_m_tdata[RES_W-1:0]);
                if (result_q.size() == 0) begin
                    $error("unexpected result transfer 0x%0h", o_m_tdata);
                    fail_cnt++;
                end else begin
                    want = result_q.pop_front();
                    check_fld("char_valid", want.char_valid, got.char_valid);
                    check_fld("char_out", want.char_out, got.char_out);
                    check_fld("word_done", want.word_done, got.word_done);
                    check_fld("word_start", want.word_start, got.word_start);
                    check_fld("word_end", want.word_end, got.word_end);
                    check_fld("closing_quote", want.closing_quote, got.closing_quote);
                    check_fld("status", want.status, got.status);
                    check_fld("pad", 0, o_m_tdata[DATA_W-1:RES_W]);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_cnt <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
